// ===== hw/rtl/timestamp_k_way_merge_core_defines.svh =====
// ----------------------------------------------------------------------------
// timestamp k-way merge core: assertion macros
// shared concurrent assertion forms for the merge core checkers
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_K_WAY_MERGE_CORE_DEFINES_SVH
`define TIMESTAMP_K_WAY_MERGE_CORE_DEFINES_SVH

// property that holds in the same cycle
`define TKWM_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define TKWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tkwm_pkg.sv =====
// ----------------------------------------------------------------------------
// tkwm_pkg
// types, codes and defaults shared by the timestamp k-way merge core
// ----------------------------------------------------------------------------
package tkwm_pkg;

    localparam int unsigned NUM_QUEUES_DEF  = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 256;

    localparam int unsigned TS_W   = 64;
    localparam int unsigned TAG_W  = 32;
    localparam int unsigned QIDX_W = 3;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned CFG_W  = 4;

    localparam logic [CFG_W-1:0] ACTIVE_RST = 4'd8;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_PUSHED = 3'd0,
        ST_POPPED = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADQ   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_FLUSH,
        S_POP
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic push_exec;
        logic scan_step;
        logic pop_exec;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
    } t_dp_stat;

endpackage

// ===== hw/rtl/tkwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkwm_ctrl
// sequencer for push and pop transactions of the merge core
// ----------------------------------------------------------------------------
module tkwm_ctrl
    import tkwm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_req_type,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.scan_init = (i_req_type == REQ_POP);
                    n_state         = (i_req_type == REQ_POP) ? S_SCAN : S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push_exec = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            // last head read still in flight to the compare stage
            S_FLUSH: begin
                n_state = S_POP;
            end
            S_POP: begin
                o_cmd.pop_exec = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/tkwm_dpath.sv =====
// ----------------------------------------------------------------------------
// tkwm_dpath
// event store, queue pointers, head scan compare and result registers
// ----------------------------------------------------------------------------
module tkwm_dpath
    import tkwm_pkg::*;
#(
    parameter int unsigned NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_cfg_valid,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [QIDX_W-1:0] i_queue_index,
    input  logic [TS_W-1:0]   i_timestamp,
    input  logic [TAG_W-1:0]  i_event_tag,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [QIDX_W-1:0] o_source_queue,
    output logic [TS_W-1:0]   o_out_timestamp,
    output logic [TAG_W-1:0]  o_out_tag
);

    localparam int unsigned IW    = $clog2(NUM_QUEUES);
    localparam int unsigned AW    = $clog2(NUM_QUEUES + 1);
    localparam int unsigned SW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MDEP  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int unsigned MAW   = $clog2(MDEP);
    localparam int unsigned ENT_W = TS_W + TAG_W;

    // configuration
    logic [CFG_W-1:0] r_active;
    logic [AW-1:0]    eff_act;

    // captured request
    logic [QIDX_W-1:0] r_q;
    logic [TS_W-1:0]   r_ts;
    logic [TAG_W-1:0]  r_tag;
    logic [IW-1:0]     r_idx;

    // per-queue pointers
    logic [SW-1:0] r_head [NUM_QUEUES];
    logic [FW-1:0] r_fill [NUM_QUEUES];

    // event store, {timestamp, tag}
    logic [ENT_W-1:0] r_mem [MDEP];
    logic [ENT_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [IW-1:0]    r_rd_idx;

    // running minimum
    logic              r_found;
    logic [IW-1:0]     r_best_idx;
    logic [TS_W-1:0]   r_best_ts;
    logic [TAG_W-1:0]  r_best_tag;

    // result
    logic              r_valid;
    logic [STAT_W-1:0] r_status;
    logic [QIDX_W-1:0] r_src;
    logic [TS_W-1:0]   r_ots;
    logic [TAG_W-1:0]  r_otag;

    logic [IW-1:0]  sel_idx;
    logic [SW-1:0]  cur_head;
    logic [FW-1:0]  cur_fill;
    logic [SW:0]    slot_sum;
    logic [SW-1:0]  push_slot;
    logic [SW-1:0]  head_inc;
    logic [MAW-1:0] queue_base;
    logic [MAW-1:0] push_addr;
    logic [MAW-1:0] head_addr;
    logic           push_bad;
    logic           push_full;
    logic           mem_we;
    logic [TS_W-1:0] rd_ts;
    logic           take_rd;

    always_comb begin
        if (r_active == '0) begin
            eff_act = AW'(1);
        end else if (32'(r_active) > NUM_QUEUES) begin
            eff_act = AW'(NUM_QUEUES);
        end else begin
            eff_act = AW'(r_active);
        end
    end

    assign o_stat.scan_last = (r_idx == IW'(eff_act - AW'(1)));

    // one pointer read port: the pop update uses the winner, all else the working index
    assign sel_idx  = i_cmd.pop_exec ? r_best_idx : r_idx;
    assign cur_head = r_head[sel_idx];
    assign cur_fill = r_fill[sel_idx];

    // tail slot = head + fill wrapped at the depth; head below the depth, fill up to it
    assign slot_sum  = (SW+1)'(cur_head) + (SW+1)'(cur_fill);
    assign push_slot = (slot_sum >= (SW+1)'(QUEUE_DEPTH))
                     ? SW'(slot_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(slot_sum);
    assign head_inc  = (cur_head == SW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + SW'(1);

    assign queue_base = MAW'(sel_idx) * MAW'(QUEUE_DEPTH);
    assign push_addr  = queue_base + MAW'(push_slot);
    assign head_addr  = queue_base + MAW'(cur_head);

    assign push_bad  = (32'(r_q) >= 32'(eff_act));
    assign push_full = (cur_fill == FW'(QUEUE_DEPTH));
    assign mem_we    = i_cmd.push_exec && !push_bad && !push_full;

    assign rd_ts   = r_rd_data[ENT_W-1 -: TS_W];
    assign take_rd = r_rd_vld && (!r_found || (rd_ts < r_best_ts));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[push_addr] <= {r_ts, r_tag};
        end
        r_rd_data <= r_mem[head_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_valid  <= 1'b0;
            r_idx    <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end

            r_valid  <= i_cmd.push_exec || i_cmd.pop_exec;
            r_rd_vld <= i_cmd.scan_step && (cur_fill != '0);
            r_rd_idx <= r_idx;

            if (i_cmd.load) begin
                r_q     <= i_queue_index;
                r_ts    <= i_timestamp;
                r_tag   <= i_event_tag;
                r_found <= 1'b0;
                // pops scan from queue zero; pushes keep the target
                r_idx   <= i_cmd.scan_init ? '0 : IW'(i_queue_index);
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + IW'(1);
            end

            // strict less keeps the lowest queue on a tie
            if (take_rd) begin
                r_found    <= 1'b1;
                r_best_idx <= r_rd_idx;
                r_best_ts  <= rd_ts;
                r_best_tag <= r_rd_data[TAG_W-1:0];
            end

            if (mem_we) begin
                r_fill[sel_idx] <= cur_fill + FW'(1);
            end

            if (i_cmd.push_exec) begin
                r_src  <= r_q;
                r_ots  <= '0;
                r_otag <= '0;
                if (push_bad) begin
                    r_status <= ST_BADQ;
                end else if (push_full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_PUSHED;
                end
            end

            if (i_cmd.pop_exec) begin
                if (r_found) begin
                    r_head[sel_idx] <= head_inc;
                    r_fill[sel_idx] <= cur_fill - FW'(1);
                    r_status        <= ST_POPPED;
                    r_src           <= QIDX_W'(r_best_idx);
                    r_ots           <= r_best_ts;
                    r_otag          <= r_best_tag;
                end else begin
                    r_status <= ST_EMPTY;
                    r_src    <= '0;
                    r_ots    <= '0;
                    r_otag   <= '0;
                end
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_source_queue  = r_src;
    assign o_out_timestamp = r_ots;
    assign o_out_tag       = r_otag;

endmodule

// ===== hw/rtl/timestamp_k_way_merge_core.sv =====
// ----------------------------------------------------------------------------
// timestamp_k_way_merge_core
// per-source event queues merged by smallest head timestamp
// ----------------------------------------------------------------------------
// channel   | handshake                    | payload
// ----------+------------------------------+------------------------------------
// request   | start, busy                  | req_type, queue_index, timestamp, tag
// result    | o_valid (one-cycle strobe)   | status, source_queue, timestamp, tag
// config    | i_cfg_valid, o_cfg_ready     | active queue count (4 bits)
//
// a push is accepted, runs the push state and strobes its result as busy drops; busy is high for a single cycle
// a pop walks the scan, flush and pop states while busy (A = effective active queue count);
// the head scan reads one queue head per cycle for the A queues through the single event store
// read port, then the flush state drains the compare and the pop state updates the pointers
// the next transaction is taken in the cycle the strobe shows the result
// reset is synchronous; queue pointers clear at once, the store is not cleared
// results cannot be stalled; the user, unchecked by the core, writes config only while the core is idle
// ----------------------------------------------------------------------------
module timestamp_k_way_merge_core
    import tkwm_pkg::*;
#(
    parameter int unsigned NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [QIDX_W-1:0] i_queue_index,
    input  logic [TS_W-1:0]   i_timestamp,
    input  logic [TAG_W-1:0]  i_event_tag,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [QIDX_W-1:0] o_source_queue,
    output logic [TS_W-1:0]   o_out_timestamp,
    output logic [TAG_W-1:0]  o_out_tag,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cmd     cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    tkwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (dp_stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    tkwm_dpath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (dp_stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_queue_index   (i_queue_index),
        .i_timestamp     (i_timestamp),
        .i_event_tag     (i_event_tag),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_source_queue  (o_source_queue),
        .o_out_timestamp (o_out_timestamp),
        .o_out_tag       (o_out_tag)
    );

endmodule

// ===== hw/rtl/tkwm_checker.sv =====
// ----------------------------------------------------------------------------
// tkwm_checker
// port-level checks of the merge core, bound to the top level
// ----------------------------------------------------------------------------
`include "timestamp_k_way_merge_core_defines.svh"

module tkwm_checker
    import tkwm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [STAT_W-1:0] o_status,
    input logic [QIDX_W-1:0] o_source_queue,
    input logic [TS_W-1:0]   o_out_timestamp,
    input logic [TAG_W-1:0]  o_out_tag
);

    // an accepted transaction always makes the core busy in the cycle after its accept
    `TKWM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")

    // every finished transaction shows its result as busy drops
    `TKWM_ASSERT_NOW(a_done_strobe, i_clk, i_rst_n, !$fell(busy) || o_valid, "busy fell without result")

    // results are single-cycle strobes
    `TKWM_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held")

    // only a pop result carries event data
    `TKWM_ASSERT_NOW(a_zero_payload, i_clk, i_rst_n,
        !o_valid || (o_status == ST_POPPED) || (o_out_timestamp == '0 && o_out_tag == '0),
        "non-pop result with event data")

    // an empty pop names no queue
    `TKWM_ASSERT_NOW(a_empty_src, i_clk, i_rst_n,
        !o_valid || (o_status != ST_EMPTY) || (o_source_queue == '0),
        "empty pop with nonzero source")

endmodule

bind timestamp_k_way_merge_core tkwm_checker u_tkwm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_status        (o_status),
    .o_source_queue  (o_source_queue),
    .o_out_timestamp (o_out_timestamp),
    .o_out_tag       (o_out_tag)
);
